// ----- sv/bank_model_selector_led_blinker_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the bank and model selector
// Shared property forms used by the block's modules.
// ----------------------------------------------------------------------------
`ifndef BANK_MODEL_SELECTOR_LED_BLINKER_ASSERT_SVH
`define BANK_MODEL_SELECTOR_LED_BLINKER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define BMSL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define BMSL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/bmsl_pkg.sv -----
// ----------------------------------------------------------------------------
// bmsl_pkg
// Types and constants of the bank and model selector with blinking LED.
// ----------------------------------------------------------------------------
package bmsl_pkg;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;
    localparam int LIMIT_BITS     = 16;
    localparam int BLINK_BITS     = 10;
    localparam int DELAY_BITS     = 16;
    localparam int START_BITS     = 3;
    localparam int MODEL_OUT_BITS = 3;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LONG_PRESS_LIMIT = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BLINK_ON_TIME    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BLINK_OFF_TIME   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SAVE_DELAY       = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_START_MODEL_A    = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_START_MODEL_B    = 3'd5;

    // register reset values
    localparam logic [LIMIT_BITS-1:0] LONG_PRESS_LIMIT_RST = 16'd500;
    localparam logic [BLINK_BITS-1:0] BLINK_ON_TIME_RST    = 10'd140;
    localparam logic [BLINK_BITS-1:0] BLINK_OFF_TIME_RST   = 10'd160;
    localparam logic [DELAY_BITS-1:0] SAVE_DELAY_RST       = 16'd2000;

    typedef struct packed {
        logic button_level;
        logic toggle_level;
        logic gate_level;
    } bmsl_tick_t;

    typedef struct packed {
        logic                      active_bank;
        logic [MODEL_OUT_BITS-1:0] active_model;
        logic                      model_changed;
        logic                      led_level;
        logic                      save_strobe;
        logic [MODEL_OUT_BITS-1:0] saved_model_a;
        logic [MODEL_OUT_BITS-1:0] saved_model_b;
    } bmsl_result_t;

    typedef struct packed {
        logic                      en;
        logic [CFG_INDEX_BITS-1:0] index;
        logic [CFG_DATA_BITS-1:0]  data;
    } bmsl_cfg_wr_t;

endpackage

// ----- sv/bmsl_core.sv -----
// ----------------------------------------------------------------------------
// bmsl_core
// Selector state, configuration registers and the per-tick update.
// ----------------------------------------------------------------------------
module bmsl_core #(
    parameter int MODELS_PER_BANK = 8,
    parameter int TIME_BITS       = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  bmsl_pkg::bmsl_tick_t  tick,
    input  bmsl_pkg::bmsl_cfg_wr_t cfg_wr,
    output bmsl_pkg::bmsl_result_t result
);

    localparam int MB = (MODELS_PER_BANK > 2) ? $clog2(MODELS_PER_BANK) : 1;
    localparam int CB = $clog2(MODELS_PER_BANK + 1);
    localparam logic [MB-1:0] MODEL_LAST = MB'(MODELS_PER_BANK - 1);

    logic [bmsl_pkg::LIMIT_BITS-1:0] long_press_limit_reg;
    logic [bmsl_pkg::BLINK_BITS-1:0] blink_on_time_reg;
    logic [bmsl_pkg::BLINK_BITS-1:0] blink_off_time_reg;
    logic [bmsl_pkg::DELAY_BITS-1:0] save_delay_reg;

    logic [TIME_BITS-1:0] tick_count_reg,   tick_count_next;
    logic                 bank_reg,         bank_next;
    logic [MB-1:0]        model_a_reg,      model_a_next;
    logic [MB-1:0]        model_b_reg,      model_b_next;
    logic                 press_active_reg, press_active_next;
    logic [TIME_BITS-1:0] press_start_reg,  press_start_next;
    logic [CB-1:0]        blink_request_reg, blink_request_next;
    logic                 request_pending_reg;
    logic [CB-1:0]        blinks_left_reg,  blinks_left_next;
    logic                 led_lit_reg,      led_lit_next;
    logic [TIME_BITS-1:0] led_deadline_reg, led_deadline_next;
    logic                 dirty_reg,        dirty_next;
    logic [TIME_BITS-1:0] dirty_since_reg,  dirty_since_next;

    logic [MB-1:0] cfg_model;

    function automatic logic [MB-1:0] model_inc(input logic [MB-1:0] m);
        return (m == MODEL_LAST) ? '0 : m + 1'b1;
    endfunction

    // start index reduced modulo the bank size, small constant table
    function automatic logic [MB-1:0] start_mod(input logic [bmsl_pkg::START_BITS-1:0] v);
        logic [MB-1:0] r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            if (v == bmsl_pkg::START_BITS'(i))
            begin
                r = MB'(i % MODELS_PER_BANK);
            end
        end
        return r;
    endfunction

    assign cfg_model = start_mod(cfg_wr.data[bmsl_pkg::START_BITS-1:0]);

    always_comb
    begin
        logic [TIME_BITS-1:0] now;
        logic [TIME_BITS-1:0] held;
        logic [TIME_BITS-1:0] led_age;
        logic [TIME_BITS-1:0] dirty_age;
        logic                 pending;
        logic                 changed;
        logic                 led_out;
        logic                 strobe;
        logic [MB-1:0]        model_sel;

        now = tick_count_reg;
        bank_next          = bank_reg;
        model_a_next       = model_a_reg;
        model_b_next       = model_b_reg;
        press_active_next  = press_active_reg;
        press_start_next   = press_start_reg;
        blink_request_next = blink_request_reg;
        pending            = request_pending_reg;
        blinks_left_next   = blinks_left_reg;
        led_lit_next       = led_lit_reg;
        led_deadline_next  = led_deadline_reg;
        dirty_next         = dirty_reg;
        dirty_since_next   = dirty_since_reg;
        changed            = 1'b0;
        strobe             = 1'b0;

        // bank toggle
        if (tick.toggle_level != bank_reg)
        begin
            bank_next          = tick.toggle_level;
            changed            = 1'b1;
            pending            = 1'b1;
            model_sel          = tick.toggle_level ? model_b_reg : model_a_reg;
            blink_request_next = CB'(model_sel) + 1'b1;
            dirty_next         = 1'b1;
            dirty_since_next   = now;
        end

        // button press and release
        held = now - press_start_reg;
        if (tick.button_level)
        begin
            if (!press_active_reg)
            begin
                press_start_next  = now;
                press_active_next = 1'b1;
            end
        end
        else if (press_active_reg)
        begin
            if (held < TIME_BITS'(long_press_limit_reg))
            begin
                if (bank_next)
                begin
                    model_b_next = model_inc(model_b_reg);
                end
                else
                begin
                    model_a_next = model_inc(model_a_reg);
                end
                changed          = 1'b1;
                dirty_next       = 1'b1;
                dirty_since_next = now;
            end
            model_sel          = bank_next ? model_b_next : model_a_next;
            blink_request_next = CB'(model_sel) + 1'b1;
            pending            = 1'b1;
            press_active_next  = 1'b0;
        end

        // LED sequencer
        if (pending)
        begin
            blinks_left_next  = blink_request_next;
            led_lit_next      = 1'b0;
            led_deadline_next = now;
        end
        led_age = now - led_deadline_next;
        if (blinks_left_next != '0)
        begin
            if (!led_age[TIME_BITS-1])
            begin
                if (!led_lit_next)
                begin
                    led_lit_next      = 1'b1;
                    led_deadline_next = now + TIME_BITS'(blink_on_time_reg);
                end
                else
                begin
                    led_lit_next      = 1'b0;
                    led_deadline_next = now + TIME_BITS'(blink_off_time_reg);
                    blinks_left_next  = blinks_left_next - 1'b1;
                end
            end
            led_out = led_lit_next;
        end
        else
        begin
            led_out = tick.gate_level;
        end

        // save timer
        dirty_age = now - dirty_since_next;
        if (dirty_next && (dirty_age > TIME_BITS'(save_delay_reg)))
        begin
            dirty_next = 1'b0;
            strobe     = 1'b1;
        end

        tick_count_next = now + 1'b1;

        model_sel            = bank_next ? model_b_next : model_a_next;
        result.active_bank   = bank_next;
        result.active_model  = bmsl_pkg::MODEL_OUT_BITS'(model_sel);
        result.model_changed = changed;
        result.led_level     = led_out;
        result.save_strobe   = strobe;
        result.saved_model_a = bmsl_pkg::MODEL_OUT_BITS'(model_a_next);
        result.saved_model_b = bmsl_pkg::MODEL_OUT_BITS'(model_b_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_limit_reg <= bmsl_pkg::LONG_PRESS_LIMIT_RST;
            blink_on_time_reg    <= bmsl_pkg::BLINK_ON_TIME_RST;
            blink_off_time_reg   <= bmsl_pkg::BLINK_OFF_TIME_RST;
            save_delay_reg       <= bmsl_pkg::SAVE_DELAY_RST;
            tick_count_reg       <= '0;
            bank_reg             <= 1'b0;
            model_a_reg          <= '0;
            model_b_reg          <= '0;
            press_active_reg     <= 1'b0;
            press_start_reg      <= '0;
            blink_request_reg    <= CB'(1);
            request_pending_reg  <= 1'b1;
            blinks_left_reg      <= '0;
            led_lit_reg          <= 1'b0;
            led_deadline_reg     <= '0;
            dirty_reg            <= 1'b0;
            dirty_since_reg      <= '0;
        end
        else if (advance)
        begin
            tick_count_reg      <= tick_count_next;
            bank_reg            <= bank_next;
            model_a_reg         <= model_a_next;
            model_b_reg         <= model_b_next;
            press_active_reg    <= press_active_next;
            press_start_reg     <= press_start_next;
            blink_request_reg   <= blink_request_next;
            request_pending_reg <= 1'b0;
            blinks_left_reg     <= blinks_left_next;
            led_lit_reg         <= led_lit_next;
            led_deadline_reg    <= led_deadline_next;
            dirty_reg           <= dirty_next;
            dirty_since_reg     <= dirty_since_next;
        end
        else if (cfg_wr.en)
        begin
            unique case (cfg_wr.index)
                bmsl_pkg::CFG_LONG_PRESS_LIMIT: long_press_limit_reg <= cfg_wr.data;
                bmsl_pkg::CFG_BLINK_ON_TIME:
                    blink_on_time_reg <= cfg_wr.data[bmsl_pkg::BLINK_BITS-1:0];
                bmsl_pkg::CFG_BLINK_OFF_TIME:
                    blink_off_time_reg <= cfg_wr.data[bmsl_pkg::BLINK_BITS-1:0];
                bmsl_pkg::CFG_SAVE_DELAY:       save_delay_reg <= cfg_wr.data;
                bmsl_pkg::CFG_START_MODEL_A:
                begin
                    model_a_reg <= cfg_model;
                    if (request_pending_reg && !bank_reg)
                    begin
                        blink_request_reg <= CB'(cfg_model) + 1'b1;
                    end
                end
                bmsl_pkg::CFG_START_MODEL_B:
                begin
                    model_b_reg <= cfg_model;
                    if (request_pending_reg && bank_reg)
                    begin
                        blink_request_reg <= CB'(cfg_model) + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    `include "bank_model_selector_led_blinker_assert.svh"

    `BMSL_ASSERT_NEXT(a_request_taken, clk, rst_n, advance, !request_pending_reg,
        "blink request still pending after a tick")
    `BMSL_ASSERT_NOW(a_blinks_bounded, clk, rst_n, 1'b1,
        blinks_left_reg <= CB'(MODELS_PER_BANK), "blink count above bank size")
    `BMSL_ASSERT_NOW(a_model_range, clk, rst_n, 1'b1,
        (model_a_reg <= MODEL_LAST) && (model_b_reg <= MODEL_LAST),
        "model index out of range")

endmodule

// ----- sv/bank_model_selector_led_blinker.sv -----
// ----------------------------------------------------------------------------
// bank_model_selector_led_blinker
// Bank and model selection from button and toggle, LED number blinker and
// delayed save strobe, one result per tick.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                  | payload
//  tick     | in        | tick_valid / tick_ready    | tick_data (bmsl_tick_t)
//  result   | out       | result_valid / result_ready| result_data (bmsl_result_t)
//  cfg      | in        | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// A tick is held in the input register, then the state update and the
// result are computed in one pass into the result register. One tick per
// cycle is sustained while result_ready is high; a waiting result stalls
// only the input register, and one more tick is still taken while it holds.
// Reset is asynchronous; cfg_ready is low while a tick waits in the input
// register.
// ----------------------------------------------------------------------------
module bank_model_selector_led_blinker #(
    parameter int MODELS_PER_BANK = 8,
    parameter int TIME_BITS       = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   tick_valid,
    output logic                                   tick_ready,
    input  bmsl_pkg::bmsl_tick_t                   tick_data,
    output logic                                   result_valid,
    input  logic                                   result_ready,
    output bmsl_pkg::bmsl_result_t                 result_data,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [bmsl_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [bmsl_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    logic                   in_valid_reg;
    bmsl_pkg::bmsl_tick_t   in_data_reg;
    logic                   out_valid_reg;
    bmsl_pkg::bmsl_result_t out_data_reg;
    logic                   advance;
    bmsl_pkg::bmsl_result_t core_result;
    bmsl_pkg::bmsl_cfg_wr_t cfg_wr;

    assign advance      = in_valid_reg && (!out_valid_reg || result_ready);
    assign tick_ready   = !in_valid_reg || advance;
    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;
    // a register write never lands on a cycle that updates the state
    assign cfg_ready    = !in_valid_reg;

    assign cfg_wr.en    = cfg_valid && cfg_ready;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    bmsl_core #(
        .MODELS_PER_BANK (MODELS_PER_BANK),
        .TIME_BITS       (TIME_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .tick    (in_data_reg),
        .cfg_wr  (cfg_wr),
        .result  (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (tick_ready)
            begin
                in_valid_reg <= tick_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_valid && tick_ready)
        begin
            in_data_reg <= tick_data;
        end
        if (advance)
        begin
            out_data_reg <= core_result;
        end
    end

    `include "bank_model_selector_led_blinker_assert.svh"

    `BMSL_ASSERT_NEXT(a_result_loaded, clk, rst_n, advance, result_valid,
        "result register empty after a tick transaction")
    `BMSL_ASSERT_NEXT(a_tick_captured, clk, rst_n, tick_valid && tick_ready, in_valid_reg,
        "accepted tick lost before processing")
    `BMSL_ASSERT_NEXT(a_tick_held, clk, rst_n,
        in_valid_reg && result_valid && !result_ready, in_valid_reg && $stable(in_data_reg),
        "pending tick dropped while result stalled")

endmodule
